// ===== rtl/core/bad_pkg.sv =====
// ----------------------------------------------------------------------------
// bad_pkg: shared types and constants of the box average downscaler
// Holds register indexes, field widths, the sum record and state codes.
// ----------------------------------------------------------------------------
package bad_pkg;

  localparam int MaxDestWidth = 256;
  localparam int MaxSourceDim = 4096;
  localparam int SlotBits     = $clog2(MaxDestWidth);
  localparam int SumBits      = 32;

  // register indexes
  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_BOX_W = 2'd2,
    REG_BOX_H = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SumBits-1:0] blue;
    logic [SumBits-1:0] green;
    logic [SumBits-1:0] red;
  } sums_t;

  // control states of the core
  typedef enum logic [4:0] {
    S_FIT0, S_FIT0W, S_FIT1, S_FIT1W, S_RST0, S_RST0W, S_RST1, S_RST1W,
    S_IDLE, S_RD, S_WR, S_CB0, S_CB0W, S_CB1, S_CB1W, S_RB, S_RBW,
    S_MR, S_MRW, S_MG, S_MGW, S_MB, S_MBW, S_EMIT, S_COLS, S_COLSW
  } st_t;

endpackage

// ===== rtl/core/bad_ram.sv =====
// ----------------------------------------------------------------------------
// bad_ram: generic simple dual-port synchronous ram
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bad_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bad_divider.sv =====
// ----------------------------------------------------------------------------
// bad_divider: radix-2 restoring divider
// Divides a 32-bit numerator by a 25-bit denominator, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bad_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [24:0] den,
  output logic        busy,
  output logic        done,
  output logic [31:0] quo
);

  logic [31:0] q;
  logic [25:0] rem;
  logic [24:0] d;
  logic [5:0]  cnt;
  logic [25:0] trial;
  logic [25:0] shifted;

  assign shifted = {rem[24:0], q[31]};
  assign trial   = shifted - {1'b0, d};
  assign quo     = q;

  // shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        rem  <= '0;
        d    <= den;
        cnt  <= 6'd32;
      end else if (busy) begin
        if (!trial[25]) begin
          rem <= trial;
          q   <= {q[30:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/box_average_image_downscaler_core.sv =====
// ----------------------------------------------------------------------------
// box_average_image_downscaler_core: box filter rgb downscaler
// Fits the output in a box, sums source rectangles, emits truncated means.
// ----------------------------------------------------------------------------
// Usage: each source pixel goes through a read-modify-write of its line store
// entry (accept, read, write back, column step), so a new pixel is not taken
// until the previous one has finished these steps. Every serial division is
// a launch state followed by a wait state. A pixel that ends a column band
// adds one division for the next band bound. The pixel that closes an output
// rectangle first runs three divisions for the channel means and an emit state
// that waits while the previous output beat is still held by the sink. The
// last pixel of a row adds one division for the first column bound, then one
// more at a row band change, or two more at the end of the frame to restart
// it. A configuration write refits the output with four divisions before
// pixels are taken again. Out of range register values are saturated; while
// the fit would enlarge the image, pixels are taken and dropped.
module box_average_image_downscaler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_red, out_green, out_blue, out_column, out_row, pad
  output logic        m_tlast    // frame_last
);
  import bad_pkg::*;

  st_t st, st_next;

  // configuration registers
  logic [12:0] src_w, src_h, box_h;
  logic [8:0]  box_w;
  logic [12:0] eff_w, eff_h, bh;
  logic [8:0]  bw;

  // frame state
  logic [8:0]  fit_w;
  logic [12:0] fit_h;
  logic        err;
  logic [12:0] scol, srow;
  logic [8:0]  dcol;
  logic [11:0] drow;
  logic [12:0] cend, cstart, rstart, rend;
  logic [23:0] px;
  logic        first;
  logic [31:0] cnt_n;
  logic        last_flag;
  logic [7:0]  o_r, o_g, o_b;
  logic        pend_cfg;
  logic        fit_refit;
  sums_t       cur_hold;
  logic        emit_go;

  // divider
  logic        dv_start, dv_busy, dv_done;
  logic [31:0] dv_num, dv_quo;
  logic [24:0] dv_den;

  // line store
  logic        ram_we;
  logic [SlotBits-1:0] slot;
  sums_t       ram_rd, ram_wd, cur;

  always_comb begin
    eff_w = (src_w == 13'd0) ? 13'd1 : (src_w > 13'd4096 ? 13'd4096 : src_w);
    eff_h = (src_h == 13'd0) ? 13'd1 : (src_h > 13'd4096 ? 13'd4096 : src_h);
    bw    = (box_w == 9'd0) ? 9'd1 : (box_w > 9'd256 ? 9'd256 : box_w);
    bh    = (box_h == 13'd0) ? 13'd1 : (box_h > 13'd4096 ? 13'd4096 : box_h);
  end

  assign slot = (dcol > 9'd255) ? 8'd255 : dcol[7:0];

  bad_divider u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .done(dv_done), .quo(dv_quo)
  );

  bad_ram #(.Width(3*SumBits), .Depth(MaxDestWidth)) u_ram (
    .clk(clk), .we(ram_we), .waddr(slot), .wdata(ram_wd), .raddr(slot),
    .rdata(ram_rd)
  );

  // config write capture
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= 13'd1; src_h <= 13'd1; box_w <= 9'd1; box_h <= 13'd1;
      pend_cfg <= 1'b1;
    end else begin
      if (cfg_we) begin
        pend_cfg <= 1'b1;
        unique case (reg_idx_t'(cfg_index))
          REG_SRC_W: src_w <= cfg_data;
          REG_SRC_H: src_h <= cfg_data;
          REG_BOX_W: box_w <= cfg_data[8:0];
          REG_BOX_H: box_h <= cfg_data;
          default: ;
        endcase
      end else if (st == S_FIT0) begin
        pend_cfg <= 1'b0;
      end
    end
  end

  logic [12:0] scol_p1, srow_p1;
  assign scol_p1  = scol + 13'd1;
  assign srow_p1  = srow + 13'd1;

  assign s_tready = (st == S_IDLE) && !pend_cfg && !cfg_we;

  // output register free or freed this cycle
  assign emit_go = !m_tvalid || m_tready;

  // add into band sum
  always_comb begin
    cur.red   = first ? 32'd0 : ram_rd.red;
    cur.green = first ? 32'd0 : ram_rd.green;
    cur.blue  = first ? 32'd0 : ram_rd.blue;
    ram_wd.red   = cur.red   + {24'd0, px[7:0]};
    ram_wd.green = cur.green + {24'd0, px[15:8]};
    ram_wd.blue  = cur.blue  + {24'd0, px[23:16]};
  end
  assign ram_we = (st == S_WR);

  // next state and divider launches
  always_comb begin
    st_next  = st;
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    unique case (st)
      S_FIT0: begin
        dv_start = 1'b1;
        dv_num = {19'd0, eff_h} * {23'd0, bw};
        dv_den = {12'd0, eff_w};
        st_next = S_FIT0W;
      end
      S_FIT0W: if (dv_done) st_next = S_FIT1;
      S_FIT1: begin
        dv_start = 1'b1;
        dv_num = {19'd0, eff_w} * {19'd0, bh};
        dv_den = {12'd0, eff_h};
        st_next = S_FIT1W;
      end
      S_FIT1W: if (dv_done) st_next = S_RST0;
      S_RST0: begin
        dv_start = 1'b1;
        dv_num = {19'd0, eff_w};
        dv_den = {16'd0, fit_w};
        st_next = S_RST0W;
      end
      S_RST0W: if (dv_done) st_next = S_RST1;
      S_RST1: begin
        dv_start = 1'b1;
        dv_num = {19'd0, eff_h};
        dv_den = {12'd0, fit_h};
        st_next = S_RST1W;
      end
      S_RST1W: if (dv_done) st_next = S_IDLE;
      S_IDLE: begin
        if (pend_cfg && !cfg_we) st_next = S_FIT0;
        else if (s_tvalid && s_tready && !err) st_next = S_RD;
      end
      S_RD: st_next = S_WR;
      S_WR: begin
        if (scol_p1 == cend) begin
          if (srow_p1 == rend) st_next = S_MR;
          else st_next = S_CB1;
        end else st_next = S_COLS;
      end
      S_MR: begin
        dv_start = 1'b1; dv_num = cur_hold.red; dv_den = cnt_n[24:0];
        st_next = S_MRW;
      end
      S_MRW: if (dv_done) st_next = S_MG;
      S_MG: begin
        dv_start = 1'b1; dv_num = cur_hold.green; dv_den = cnt_n[24:0];
        st_next = S_MGW;
      end
      S_MGW: if (dv_done) st_next = S_MB;
      S_MB: begin
        dv_start = 1'b1; dv_num = cur_hold.blue; dv_den = cnt_n[24:0];
        st_next = S_MBW;
      end
      S_MBW: if (dv_done) st_next = S_EMIT;
      S_EMIT: if (emit_go) st_next = S_CB1;
      S_CB1: begin
        // next column band end: (dcol+1)*W/w, dcol already advanced
        dv_start = 1'b1;
        dv_num = {10'd0, ({13'd0, dcol} + 22'd1) * {9'd0, eff_w}};
        dv_den = {16'd0, fit_w};
        st_next = S_CB1W;
      end
      S_CB1W: if (dv_done) st_next = S_COLS;
      S_COLS: begin
        if (scol >= eff_w) begin
          st_next = S_CB0;
        end else st_next = S_IDLE;
      end
      S_CB0: begin
        dv_start = 1'b1;
        dv_num = {19'd0, eff_w};
        dv_den = {16'd0, fit_w};
        st_next = S_CB0W;
      end
      S_CB0W: if (dv_done) st_next = S_RB;
      S_RB: begin
        if (srow >= eff_h) st_next = S_RST0;
        else if (srow >= rend) begin
          // next row band end: (drow+2)*H/h, drow advances on this edge
          dv_start = 1'b1;
          dv_num = {7'd0, ({13'd0, drow} + 25'd2) * {12'd0, eff_h}};
          dv_den = {12'd0, fit_h};
          st_next = S_RBW;
        end else st_next = S_IDLE;
      end
      S_RBW: if (dv_done) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
    if (pend_cfg && st == S_IDLE && !cfg_we) st_next = S_FIT0;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_FIT0;
      m_tvalid <= 1'b0;
      err <= 1'b0;
      fit_w <= 9'd1; fit_h <= 13'd1;
      scol <= '0; srow <= '0; dcol <= '0; drow <= '0;
      cend <= 13'd1; cstart <= '0; rstart <= '0; rend <= 13'd1;
    end else begin
      st <= st_next;
      if (st == S_FIT0W && dv_done) begin
        if (dv_quo > {19'd0, bh}) fit_h <= bh;
        else fit_h <= (dv_quo[12:0] == 13'd0) ? 13'd1 : dv_quo[12:0];
        fit_w <= bw;
        fit_refit <= dv_quo > {19'd0, bh};
      end
      // width refit only when the first fit overflowed the box height
      if (st == S_FIT1W && dv_done && fit_refit) begin
        fit_w <= (dv_quo[8:0] == 9'd0) ? 9'd1 : dv_quo[8:0];
      end
      if (st == S_RST0W && dv_done) begin
        cend <= dv_quo[12:0];
        err  <= ({4'd0, fit_w} > eff_w) || (fit_h > eff_h);
        scol <= '0; srow <= '0; dcol <= '0; drow <= '0;
        cstart <= '0; rstart <= '0;
      end
      if (st == S_RST1W && dv_done) rend <= dv_quo[12:0];
      if (st == S_IDLE && s_tvalid && s_tready && !err && !(pend_cfg)) begin
        px <= s_tdata;
        first <= (srow == rstart) && (scol == cstart);
      end
      if (st == S_WR) begin
        cur_hold <= ram_wd;
        cnt_n <= {19'd0, cend - cstart} * {19'd0, rend - rstart};
        last_flag <= ({4'd0, dcol} + 13'd1 == {4'd0, fit_w}) &&
                     ({1'b0, drow} + 13'd1 == fit_h);
        if (scol_p1 == cend) begin
          cstart <= cend;
          dcol <= dcol + 9'd1;
        end
        scol <= scol_p1;
      end
      if (st == S_MRW && dv_done) o_r <= dv_quo[7:0];
      if (st == S_MGW && dv_done) o_g <= dv_quo[7:0];
      if (st == S_MBW && dv_done) o_b <= dv_quo[7:0];
      // output beat register
      if (st == S_EMIT && emit_go) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {4'd0, drow, dcol[7:0] - 8'd1, o_b, o_g, o_r};
        m_tlast  <= last_flag;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (st == S_CB1W && dv_done) cend <= dv_quo[12:0];
      if (st == S_COLS && scol >= eff_w) begin
        scol <= '0; dcol <= '0; cstart <= '0;
        srow <= srow + 13'd1;
      end
      if (st == S_CB0W && dv_done) cend <= dv_quo[12:0];
      if (st == S_RB && srow < eff_h && srow >= rend) begin
        drow <= drow + 12'd1;
        rstart <= rend;
      end
      if (st == S_RBW && dv_done) rend <= dv_quo[12:0];
    end
  end

  // error blocks output
  a_no_out_on_err: assert property (@(posedge clk) disable iff (rst)
    (st == S_EMIT && err) |-> 1'b0) else $error("emit while in error");
  a_tready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (st == S_IDLE)) else $error("ready outside idle");
  a_no_write_while_div: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !dv_busy) else $error("store write during division");

endmodule

// ===== verif/box_average_image_downscaler_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_image_downscaler_core_tb: self-checking bench of the downscaler
// Streams rgb source frames under several box settings, predicts each output
// pixel from an in-bench box average model and checks every output beat.
// ----------------------------------------------------------------------------
module box_average_image_downscaler_core_tb;
  import bad_pkg::*;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  column;
    logic [11:0] row;
    logic        last;
  } out_pix_t;

  localparam int CfgSettle = 200;
  localparam longint CycleLimit = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // in_red, in_green, in_blue
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // out_red, out_green, out_blue, out_column, out_row, pad
  logic        m_tlast;        // frame_last

  box_average_image_downscaler_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // downscaler prediction state
  int unsigned reg_sw = 1, reg_sh = 1, reg_bw = 1, reg_bh = 1;
  int unsigned src_w, src_h, fit_w, fit_h;
  bit          upscale_err;
  int unsigned col_cnt, row_cnt, dcol, drow, col_end, row_start, row_end;
  longint unsigned col_sum [MaxDestWidth][3];

  pixel_t      pending_pixels[$];
  out_pix_t    expected_pixels[$];
  int          fail_count = 0;
  longint      cycle_count = 0;
  int unsigned outputs_seen = 0;

  function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void restart_frame();
    col_cnt = 0; row_cnt = 0; dcol = 0; drow = 0;
    col_end = src_w / fit_w;
    row_start = 0;
    row_end = src_h / fit_h;
  endfunction

  function automatic void fit_box();
    int unsigned bw, bh, w, h;
    bw = sat(reg_bw, 1, MaxDestWidth);
    bh = sat(reg_bh, 1, MaxSourceDim);
    src_w = sat(reg_sw, 1, MaxSourceDim);
    src_h = sat(reg_sh, 1, MaxSourceDim);
    w = bw;
    h = (src_h * w) / src_w;
    if (h > bh) begin
      h = bh;
      w = (src_w * h) / src_h;
    end
    if (w < 1) w = 1;
    if (h < 1) h = 1;
    fit_w = w; fit_h = h;
    upscale_err = (w > src_w) || (h > src_h);
    restart_frame();
  endfunction

  // one source pixel through the box average model
  function automatic void predict_pixel(pixel_t px);
    int unsigned slot, cstart;
    longint unsigned n;
    longint unsigned ch[3];
    out_pix_t o;
    if (upscale_err) return;
    ch[0] = px.red; ch[1] = px.green; ch[2] = px.blue;
    slot = (dcol >= MaxDestWidth) ? MaxDestWidth - 1 : dcol;
    cstart = (dcol * src_w) / fit_w;
    for (int k = 0; k < 3; k++) begin
      if (row_cnt == row_start && col_cnt == cstart) col_sum[slot][k] = ch[k];
      else col_sum[slot][k] = col_sum[slot][k] + ch[k];
      col_sum[slot][k] &= 64'hFFFF_FFFF;
    end
    if (col_cnt + 1 == col_end) begin
      if (row_cnt + 1 == row_end) begin
        n = longint'(col_end - cstart) * longint'(row_end - row_start);
        if (n == 0) n = 1;
        o.red    = 8'(col_sum[slot][0] / n);
        o.green  = 8'(col_sum[slot][1] / n);
        o.blue   = 8'(col_sum[slot][2] / n);
        o.column = 8'(dcol);
        o.row    = 12'(drow);
        o.last   = (dcol + 1 == fit_w) && (drow + 1 == fit_h);
        expected_pixels.push_back(o);
      end
      dcol++;
      col_end = ((dcol + 1) * src_w) / fit_w;
    end
    col_cnt++;
    if (col_cnt >= src_w) begin
      col_cnt = 0;
      dcol = 0;
      col_end = src_w / fit_w;
      row_cnt++;
      if (row_cnt >= row_end) begin
        drow++;
        row_start = row_end;
        row_end = ((drow + 1) * src_h) / fit_h;
      end
      if (row_cnt >= src_h) restart_frame();
    end
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("box_average_image_downscaler_core verification failed");
      $finish;
    end
  end

  // source driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  bit driving = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0 || !driving || pending_pixels.size() == 0) begin
        s_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        s_tdata <= pending_pixels.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // accepted source beats feed the prediction
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) predict_pixel(pixel_t'(s_tdata));
  end

  // sink stall pattern and output beat check
  int stall_phase = 0;
  always @(posedge clk) begin
    out_pix_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 64) % 3)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 1) == 0);
      endcase
      if (m_tvalid && m_tready) begin
        outputs_seen <= outputs_seen + 1;
        got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
               m_tdata[43:32], m_tlast};
        if (expected_pixels.size() == 0) begin
          $error("unexpected output beat col=%0d row=%0d", got.column, got.row);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.red != want.red) begin
            $error("out_red exp %0d got %0d", want.red, got.red); fail_count++;
          end
          if (got.green != want.green) begin
            $error("out_green exp %0d got %0d", want.green, got.green); fail_count++;
          end
          if (got.blue != want.blue) begin
            $error("out_blue exp %0d got %0d", want.blue, got.blue); fail_count++;
          end
          if (got.column != want.column) begin
            $error("out_column exp %0d got %0d", want.column, got.column); fail_count++;
          end
          if (got.row != want.row) begin
            $error("out_row exp %0d got %0d", want.row, got.row); fail_count++;
          end
          if (got.last != want.last) begin
            $error("frame_last exp %0d got %0d", want.last, got.last); fail_count++;
          end
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 13'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SRC_W: reg_sw = val & 13'h1FFF;
      REG_SRC_H: reg_sh = val & 13'h1FFF;
      REG_BOX_W: reg_bw = val & 9'h1FF;
      default:   reg_bh = val & 13'h1FFF;
    endcase
    fit_box();
    repeat (CfgSettle) @(posedge clk);
  endtask

  task automatic setup(int unsigned sw, int unsigned sh, int unsigned bw, int unsigned bh);
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_BOX_W, bw);
    write_reg(REG_BOX_H, bh);
  endtask

  // hand pixels to the driver and wait for the block to drain
  task automatic stream(int unsigned count, bit extremes);
    pixel_t p;
    for (int i = 0; i < count; i++) begin
      if (extremes) p = (i % 2) ? 24'hFFFFFF : 24'h000000;
      else p = pixel_t'($urandom());
      pending_pixels.push_back(p);
    end
    driving = 1'b1;
    while (pending_pixels.size() != 0 || s_tvalid) @(posedge clk);
    driving = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (CfgSettle) @(posedge clk);
  endtask

  initial begin
    int unsigned sw, sh, bw, bh;
    fit_box();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset setting, extremes of color, uneven bands
    stream(4, 1'b0);
    setup(4, 3, 2, 4096);
    stream(12, 1'b1);
    setup(5, 3, 3, 2);
    stream(15, 1'b0);
    // enlargement: pixels ignored, then cleared by a fitting write
    setup(2, 2, 4, 4096);
    stream(5, 1'b0);
    write_reg(REG_BOX_W, 2);
    stream(4, 1'b1);
    // wide source, box width at maximum and out-of-range register values
    setup(300, 1, 256, 8191);
    stream(300, 1'b0);
    setup(8191, 1, 511, 1);
    stream(40, 1'b0);
    setup(1, 1, 1, 1);

    // random frames, mostly small sizes
    for (int f = 0; f < 18; f++) begin
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 10);
      bw = $urandom_range(1, 8);
      bh = $urandom_range(1, 8);
      if (f == 9) begin
        sw = 4096; sh = 1; bw = 256; bh = 1;
      end
      setup(sw, sh, bw, bh);
      stream((f == 9) ? 300 : sw * sh + $urandom_range(0, 3), 1'b0);
    end
    stream(0, 1'b0);
    if (fail_count == 0)
      $display("box_average_image_downscaler_core verification clean");
    else
      $display("box_average_image_downscaler_core verification failed");
    $finish;
  end

endmodule
